[hdl/rtd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle tile divider package
// Shared widths and result status codes.
// ----------------------------------------------------------------------------
package rtd_pkg;

    localparam int COUNT_BITS  = 4;
    localparam int STATUS_BITS = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_TILE       = 2'd0,
        STATUS_ZERO_COUNT = 2'd1,
        STATUS_NO_TILES   = 2'd2
    } status_t;

endpackage
`default_nettype wire

[hdl/rtd_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle tile divider: iterative restoring divider
// Divides a DIVIDEND_BITS wide value by a small count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rtd_div
    import rtd_pkg::*;
#(
    parameter int DIVIDEND_BITS = 17
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [COUNT_BITS-1:0]    divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [COUNT_BITS-1:0]    rem_reg;
    logic [COUNT_BITS-1:0]    div_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [COUNT_BITS:0]      trial;
    logic                     fits;
    logic [COUNT_BITS:0]      diff;

    // The remainder stays below the divisor, so one extra bit covers the shifted trial.
    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIVIDEND_BITS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
                rem_reg <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[hdl/rectangle_tile_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// Order: a zero-count or empty-rectangle word passes through S_SINGLE to a single status word.
// Otherwise the shared divider computes the tile width and then the tile height, and then
// tiles leave one per cycle while m_tready allows, up to MAX_COLS * MAX_ROWS of them.
// The input is not ready again until the last tile has been loaded into the output register.
// Reset is asynchronous and active low; it returns the sequencer to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
// Rectangle tile divider
// Splits an inclusive grid rectangle into row-major tiles of ceiling size.
// ----------------------------------------------------------------------------
module rectangle_tile_divider
    import rtd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int MAX_COLS   = 8,
    parameter int MAX_ROWS   = 8
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    // s_tdata: region_min_x, region_min_y, region_max_x, region_max_y,
    //          column_count, row_count, zero padding
    input  wire logic                                           s_tvalid,
    output logic                                                s_tready,
    input  wire logic [8*((4*COORD_BITS+2*COUNT_BITS+7)/8)-1:0] s_tdata,
    // m_tdata: tile_min_x, tile_min_y, tile_max_x, tile_max_y, zero padding
    output logic                                                m_tvalid,
    input  wire logic                                           m_tready,
    output logic [8*((4*COORD_BITS+7)/8)-1:0]                   m_tdata,
    // m_tuser: status
    output logic [STATUS_BITS-1:0]                              m_tuser,
    output logic                                                m_tlast
);

    localparam int CB      = COORD_BITS;
    localparam int DW      = COORD_BITS + 1;
    localparam int SW      = COORD_BITS + 2;
    localparam int M_DATA_W = 8 * ((4 * COORD_BITS + 7) / 8);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_DIV_X,
        S_DIV_Y,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic [CB-1:0]         rx0_reg, ry0_reg, rx1_reg, ry1_reg;
    logic [CB-1:0]         x0_reg, y0_reg;
    logic [COUNT_BITS-1:0] nc_reg, nr_reg, col_reg, row_reg;
    logic [DW-1:0]         tw_reg, th_reg, divy_reg;
    status_t               pend_status_reg;
    logic                  m_tvalid_reg;
    logic [CB-1:0]         o_x0_reg, o_y0_reg, o_x1_reg, o_y1_reg;
    status_t               o_status_reg;
    logic                  o_last_reg;

    // Input unpacking
    logic [CB-1:0]         in_x0, in_y0, in_x1, in_y1;
    logic [COUNT_BITS-1:0] in_nc, in_nr, nc_sat, nr_sat;
    logic [DW-1:0]         ext_x, ext_y, divx_in, divy_in;
    logic                  accept, zero_count, empty_rect;

    assign in_x0 = s_tdata[0*CB +: CB];
    assign in_y0 = s_tdata[1*CB +: CB];
    assign in_x1 = s_tdata[2*CB +: CB];
    assign in_y1 = s_tdata[3*CB +: CB];
    assign in_nc = s_tdata[4*CB +: COUNT_BITS];
    assign in_nr = s_tdata[4*CB+COUNT_BITS +: COUNT_BITS];

    assign nc_sat = (in_nc > COUNT_BITS'(MAX_COLS)) ? COUNT_BITS'(MAX_COLS) : in_nc;
    assign nr_sat = (in_nr > COUNT_BITS'(MAX_ROWS)) ? COUNT_BITS'(MAX_ROWS) : in_nr;

    assign ext_x = (in_x1 >= in_x0) ? ({1'b0, in_x1} - {1'b0, in_x0} + DW'(1)) : '0;
    assign ext_y = (in_y1 >= in_y0) ? ({1'b0, in_y1} - {1'b0, in_y0} + DW'(1)) : '0;

    // Ceiling division as floor((extent + count - 1) / count).
    assign divx_in = ext_x + DW'(nc_sat) - DW'(1);
    assign divy_in = ext_y + DW'(nr_sat) - DW'(1);

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign zero_count = (in_nc == '0) || (in_nr == '0);
    assign empty_rect = (ext_x == '0) || (ext_y == '0);

    // Shared divider, first for the tile width, then for the tile height
    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_quotient;
    logic [COUNT_BITS-1:0] div_divisor;

    assign div_start    = (accept && !zero_count && !empty_rect)
                          || (state_reg == S_DIV_X && div_done);
    assign div_dividend = (state_reg == S_IDLE) ? divx_in : divy_reg;
    assign div_divisor  = (state_reg == S_IDLE) ? nc_sat : nr_reg;

    rtd_div #(
        .DIVIDEND_BITS (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Tile walk. Surviving columns and rows form a prefix, so the walk stops at the
    // first one whose minimum lies past the rectangle's maximum.
    logic [SW-1:0]         x1_sum, y1_sum, nx_sum, ny_sum;
    logic [CB-1:0]         x1_clip, y1_clip;
    logic [COUNT_BITS-1:0] col_inc, row_inc;
    logic                  next_col, next_row, out_free;

    assign x1_sum  = {2'b0, x0_reg} + {1'b0, tw_reg} - SW'(1);
    assign y1_sum  = {2'b0, y0_reg} + {1'b0, th_reg} - SW'(1);
    assign x1_clip = (x1_sum > {2'b0, rx1_reg}) ? rx1_reg : x1_sum[CB-1:0];
    assign y1_clip = (y1_sum > {2'b0, ry1_reg}) ? ry1_reg : y1_sum[CB-1:0];
    assign nx_sum  = {2'b0, x0_reg} + {1'b0, tw_reg};
    assign ny_sum  = {2'b0, y0_reg} + {1'b0, th_reg};
    assign col_inc = col_reg + COUNT_BITS'(1);
    assign row_inc = row_reg + COUNT_BITS'(1);
    assign next_col = (col_inc < nc_reg) && (nx_sum <= {2'b0, rx1_reg});
    assign next_row = (row_inc < nr_reg) && (ny_sum <= {2'b0, ry1_reg});
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rx0_reg         <= '0;
            ry0_reg         <= '0;
            rx1_reg         <= '0;
            ry1_reg         <= '0;
            x0_reg          <= '0;
            y0_reg          <= '0;
            nc_reg          <= '0;
            nr_reg          <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            tw_reg          <= '0;
            th_reg          <= '0;
            divy_reg        <= '0;
            pend_status_reg <= STATUS_TILE;
            m_tvalid_reg    <= 1'b0;
            o_x0_reg        <= '0;
            o_y0_reg        <= '0;
            o_x1_reg        <= '0;
            o_y1_reg        <= '0;
            o_status_reg    <= STATUS_TILE;
            o_last_reg      <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rx0_reg  <= in_x0;
                        ry0_reg  <= in_y0;
                        rx1_reg  <= in_x1;
                        ry1_reg  <= in_y1;
                        nc_reg   <= nc_sat;
                        nr_reg   <= nr_sat;
                        divy_reg <= divy_in;
                        priority if (zero_count)
                        begin
                            pend_status_reg <= STATUS_ZERO_COUNT;
                            state_reg       <= S_SINGLE;
                        end
                        else if (empty_rect)
                        begin
                            pend_status_reg <= STATUS_NO_TILES;
                            state_reg       <= S_SINGLE;
                        end
                        else
                        begin
                            state_reg <= S_DIV_X;
                        end
                    end
                end
                S_SINGLE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        o_x0_reg     <= '0;
                        o_y0_reg     <= '0;
                        o_x1_reg     <= '0;
                        o_y1_reg     <= '0;
                        o_status_reg <= pend_status_reg;
                        o_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_DIV_X:
                begin
                    if (div_done)
                    begin
                        tw_reg    <= div_quotient;
                        state_reg <= S_DIV_Y;
                    end
                end
                S_DIV_Y:
                begin
                    if (div_done)
                    begin
                        th_reg    <= div_quotient;
                        x0_reg    <= rx0_reg;
                        y0_reg    <= ry0_reg;
                        col_reg   <= '0;
                        row_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        o_x0_reg     <= x0_reg;
                        o_y0_reg     <= y0_reg;
                        o_x1_reg     <= x1_clip;
                        o_y1_reg     <= y1_clip;
                        o_status_reg <= STATUS_TILE;
                        o_last_reg   <= !next_col && !next_row;
                        priority if (next_col)
                        begin
                            col_reg <= col_inc;
                            x0_reg  <= nx_sum[CB-1:0];
                        end
                        else if (next_row)
                        begin
                            col_reg <= '0;
                            x0_reg  <= rx0_reg;
                            row_reg <= row_inc;
                            y0_reg  <= ny_sum[CB-1:0];
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({o_y1_reg, o_x1_reg, o_y0_reg, o_x0_reg});
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_EMIT || state_reg == S_SINGLE) |-> !div_done)
        else $error("divider finished outside a division state");

    // A non-empty rectangle always gives tiles at least one unit wide and high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (tw_reg != '0 && th_reg != '0))
        else $error("zero tile size while emitting");

    // Emitted tiles are never inverted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && o_status_reg == STATUS_TILE)
            |-> (o_x0_reg <= o_x1_reg && o_y0_reg <= o_y1_reg))
        else $error("tile minimum past its maximum");

    // Error and empty results stand alone and close their input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && o_status_reg != STATUS_TILE) |-> o_last_reg)
        else $error("status result without last");

endmodule
`default_nettype wire

[bench/rectangle_tile_divider_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle tile divider testbench
// Streams rectangles with column and row counts into the divider and checks
// every tile word against an in-bench predictor of the row-major ceiling
// split. Covered: zero counts, empty rectangles, count saturation, edge
// clipping, skipped tiles and random traffic with random stalls on both sides.
// ----------------------------------------------------------------------------
module rectangle_tile_divider_tb
    import rtd_pkg::*;
;

    localparam int COORD_BITS = 16;
    localparam int MAX_COLS   = 8;
    localparam int MAX_ROWS   = 8;
    localparam int RANDOM_REGIONS = 480;

    typedef struct {
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
        logic [COUNT_BITS-1:0] cols;
        logic [COUNT_BITS-1:0] rows;
    } region_t;

    typedef struct {
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
        status_t               status;
        logic                  last;
    } tile_t;

    class tile_scoreboard;
        tile_t tile_q[$];
        int mismatches = 0;
        int regions = 0;
        int tiles = 0;
        int zero_counts = 0;
        int empties = 0;

        task report(input string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function longint span(input longint lo, input longint hi);
            return (hi < lo) ? 0 : hi - lo + 1;
        endfunction

        function void push_tile(input longint x0, input longint y0, input longint x1,
                                input longint y1, input status_t st, input logic lst);
            tile_t t;
            t.min_x = x0[COORD_BITS-1:0];
            t.min_y = y0[COORD_BITS-1:0];
            t.max_x = x1[COORD_BITS-1:0];
            t.max_y = y1[COORD_BITS-1:0];
            t.status = st;
            t.last = lst;
            tile_q.insert(tile_q.size(), t);
        endfunction

        // Expands one accepted rectangle into its expected tile words.
        function void note_region(input region_t r);
            longint rx0, ry0, rx1, ry1, tw, th, x0, y0, x1, y1, nc, nr, row, col;
            int produced;
            rx0 = longint'(r.min_x);
            ry0 = longint'(r.min_y);
            rx1 = longint'(r.max_x);
            ry1 = longint'(r.max_y);
            nc = longint'(r.cols);
            nr = longint'(r.rows);
            produced = 0;
            regions++;
            if (nc == 0 || nr == 0) begin
                push_tile(0, 0, 0, 0, STATUS_ZERO_COUNT, 1'b1);
                zero_counts++;
                return;
            end
            if (nc > MAX_COLS) nc = longint'(MAX_COLS);
            if (nr > MAX_ROWS) nr = longint'(MAX_ROWS);
            tw = (span(rx0, rx1) + nc - 1) / nc;
            th = (span(ry0, ry1) + nr - 1) / nr;
            for (row = 0; row < nr; row++) begin
                y0 = ry0 + th * row;
                y1 = y0 + th - 1;
                if (y1 > ry1) y1 = ry1;
                for (col = 0; col < nc; col++) begin
                    x0 = rx0 + tw * col;
                    x1 = x0 + tw - 1;
                    if (x1 > rx1) x1 = rx1;
                    if (x0 <= x1 && y0 <= y1) begin
                        push_tile(x0, y0, x1, y1, STATUS_TILE, 1'b0);
                        produced++;
                    end
                end
            end
            if (produced == 0) begin
                push_tile(0, 0, 0, 0, STATUS_NO_TILES, 1'b1);
                empties++;
            end else begin
                tile_q[tile_q.size()-1].last = 1'b1;
                tiles += produced;
            end
        endfunction

        task check_tile(input tile_t got);
            tile_t want;
            if (tile_q.size() == 0) begin
                report($sformatf("tile word with nothing expected: x %0d..%0d y %0d..%0d",
                                 got.min_x, got.max_x, got.min_y, got.max_y));
                return;
            end
            want = tile_q.pop_front();
            if (got.min_x !== want.min_x)
                report($sformatf("tile_min_x %0d, expected %0d", got.min_x, want.min_x));
            if (got.min_y !== want.min_y)
                report($sformatf("tile_min_y %0d, expected %0d", got.min_y, want.min_y));
            if (got.max_x !== want.max_x)
                report($sformatf("tile_max_x %0d, expected %0d", got.max_x, want.max_x));
            if (got.max_y !== want.max_y)
                report($sformatf("tile_max_y %0d, expected %0d", got.max_y, want.max_y));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("last %0b, expected %0b", got.last, want.last));
        endtask

        function int pending();
            return tile_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [71:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;
    logic [STATUS_BITS-1:0] m_tuser;
    logic                  m_tlast;

    tile_scoreboard sb = new();
    int sent = 0;

    rectangle_tile_divider #(
        .COORD_BITS(COORD_BITS),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int draw_gap(input bit quiet);
        if (quiet) return 0;
        return int'($urandom_range(0, 13));
    endfunction

    function automatic region_t mk(input int x0, input int y0, input int x1, input int y1,
                                   input int nc, input int nr);
        region_t r;
        r.min_x = x0[COORD_BITS-1:0];
        r.min_y = y0[COORD_BITS-1:0];
        r.max_x = x1[COORD_BITS-1:0];
        r.max_y = y1[COORD_BITS-1:0];
        r.cols = nc[COUNT_BITS-1:0];
        r.rows = nr[COUNT_BITS-1:0];
        return r;
    endfunction

    // Mostly narrow spans so that tiles get clipped and skipped, with some
    // wide, empty and unordered ones mixed in.
    function automatic void draw_axis(output logic [COORD_BITS-1:0] lo,
                                      output logic [COORD_BITS-1:0] hi);
        int pick, a, b, ext;
        pick = $urandom_range(0, 99);
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        if (pick < 60) begin
            ext = $urandom_range(1, 40);
            b = (a + ext - 1 > 65535) ? 65535 : a + ext - 1;
        end else if (pick < 80) begin
            if (b < a) begin
                ext = a;
                a = b;
                b = ext;
            end
        end else if (pick < 90) begin
            if (a == 0) a = 1;
            b = $urandom_range(0, a - 1);
        end
        lo = a[COORD_BITS-1:0];
        hi = b[COORD_BITS-1:0];
    endfunction

    function automatic region_t random_region();
        region_t r;
        int pick;
        draw_axis(r.min_x, r.max_x);
        draw_axis(r.min_y, r.max_y);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            r.cols = '0;
            r.rows = COUNT_BITS'($urandom_range(0, 15));
        end else if (pick < 10) begin
            r.cols = COUNT_BITS'($urandom_range(0, 15));
            r.rows = '0;
        end else if (pick < 22) begin
            r.cols = COUNT_BITS'($urandom_range(0, 15));
            r.rows = COUNT_BITS'($urandom_range(0, 15));
        end else begin
            r.cols = COUNT_BITS'($urandom_range(1, MAX_COLS));
            r.rows = COUNT_BITS'($urandom_range(1, MAX_ROWS));
        end
        return r;
    endfunction

    // Valid stays high across back-to-back words; it only drops for a gap.
    task automatic send_region(input region_t r);
        int gap;
        gap = draw_gap(((sent / 40) % 3) == 1);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {r.rows, r.cols, r.max_y, r.max_x, r.min_y, r.min_x};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_region(r);
        sent++;
    endtask

    initial
    begin : tile_sink
        int gap;
        int seen;
        tile_t got;
        seen = 0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(((seen / 50) % 3) == 2);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.min_x  = m_tdata[15:0];
            got.min_y  = m_tdata[31:16];
            got.max_x  = m_tdata[47:32];
            got.max_y  = m_tdata[63:48];
            got.status = status_t'(m_tuser);
            got.last   = m_tlast;
            sb.check_tile(got);
            seen++;
        end
    end

    initial
    begin : stimulus
        int i;
        int waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_region(mk(0, 0, 65535, 65535, 8, 8));
        send_region(mk(0, 0, 0, 0, 1, 1));
        send_region(mk(65535, 65535, 65535, 65535, 1, 1));
        send_region(mk(10, 20, 30, 40, 0, 3));
        send_region(mk(10, 20, 30, 40, 3, 0));
        send_region(mk(10, 20, 30, 40, 0, 0));
        send_region(mk(100, 100, 199, 199, 15, 15));
        send_region(mk(0, 0, 65535, 65535, 9, 12));
        send_region(mk(10, 0, 9, 50, 4, 4));
        send_region(mk(0, 65535, 50, 0, 4, 4));
        send_region(mk(65535, 65535, 0, 0, 8, 8));
        // Narrow spans: tiles past the far edge are dropped on both axes.
        send_region(mk(0, 0, 9, 2, 8, 8));
        send_region(mk(65535, 65535, 65535, 65535, 8, 8));
        send_region(mk(65530, 65530, 65535, 65535, 4, 4));
        send_region(mk(0, 0, 65535, 65535, 7, 3));
        send_region(mk(1, 1, 65534, 65534, 5, 6));
        send_region(mk(500, 500, 400, 400, 0, 5));
        send_region(mk(3, 0, 3, 7, 1, 8));
        send_region(mk(0, 9, 6, 9, 8, 1));
        send_region(mk(43690, 21845, 65535, 43690, 15, 1));
        send_region(mk(21845, 43690, 43690, 65535, 2, 15));

        for (i = 0; i < RANDOM_REGIONS; i++)
            send_region(random_region());
        s_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        // Let any stray word show up before the final verdict.
        repeat (150) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d tile words never arrived", sb.pending()));

        $display("Sent %0d rectangles: %0d tiles, %0d zero-count and %0d empty results.",
                 sb.regions, sb.tiles, sb.zero_counts, sb.empties);
        $display("Stalls of 0 to 13 cycles on both sides, %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
hdl/rtd_pkg.sv
hdl/rtd_div.sv
hdl/rectangle_tile_divider.sv
bench/rectangle_tile_divider_tb.sv
